[rtl/dlpd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package dlpd_pkg;

    localparam int HEADER_DIGITS = 4;
    localparam int LEN_W         = 14;
    localparam int DIGITS_W      = 2;

    typedef logic [1:0]       status_t;
    typedef logic [LEN_W-1:0] len_t;
    typedef logic [7:0]       byte_t;

    localparam status_t ST_OK         = 2'd0;
    localparam status_t ST_BAD_DIGIT  = 2'd1;
    localparam status_t ST_ZERO_LEN   = 2'd2;
    localparam status_t ST_NO_NEWLINE = 2'd3;

    localparam byte_t CHAR_ZERO    = 8'h30;
    localparam byte_t CHAR_NINE    = 8'h39;
    localparam byte_t CHAR_NEWLINE = 8'h0A;

endpackage
`default_nettype wire

[rtl/decimal_length_prefix_deframer.sv]
`timescale 1ns / 1ps
`default_nettype none
// Each accepted input transaction's result is registered in the output register.
// Throughput: 1 byte per cycle; s_ready is high while the output register is
// empty or being drained the same cycle.
// Reset (aresetn low, synchronous): header parsing restarts with no digits
// seen, and the output register is emptied.
module decimal_length_prefix_deframer (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  wire  dlpd_pkg::byte_t s_in_byte,
    output logic                  m_valid,
    input  wire                   m_ready,
    output logic                  m_has_data,
    output dlpd_pkg::byte_t       m_data_byte,
    output logic                  m_frame_done,
    output dlpd_pkg::status_t     m_status
);
    import dlpd_pkg::*;

    logic                in_body_reg, in_body_next;
    logic [DIGITS_W-1:0] digits_seen_reg, digits_seen_next;
    len_t                length_accum_reg, length_accum_next;
    len_t                bytes_left_reg, bytes_left_next;

    logic                m_valid_reg;
    logic                has_data_reg, has_data_next;
    byte_t               data_byte_reg, data_byte_next;
    logic                frame_done_reg, frame_done_next;
    status_t             status_reg, status_next;

    logic                accept;
    logic                is_digit;
    logic [3:0]          digit_val;
    len_t                acc_new;
    logic [DIGITS_W-1:0] digits_inc;
    logic                hdr_complete;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign is_digit  = (s_in_byte >= CHAR_ZERO) && (s_in_byte <= CHAR_NINE);
    // low nibble of an ASCII digit is its value
    assign digit_val = s_in_byte[3:0];
    // accum * 10 + digit, kept to LEN_W bits
    assign acc_new   = {length_accum_reg[LEN_W-4:0], 3'b000}
                     + {length_accum_reg[LEN_W-2:0], 1'b0}
                     + {{(LEN_W-4){1'b0}}, digit_val};
    assign digits_inc   = digits_seen_reg + {{(DIGITS_W-1){1'b0}}, 1'b1};
    assign hdr_complete = (digits_inc == '0)
                       || ({1'b0, digits_inc} >= (DIGITS_W+1)'(HEADER_DIGITS));

    always_comb begin
        in_body_next      = in_body_reg;
        digits_seen_next  = digits_seen_reg;
        length_accum_next = length_accum_reg;
        bytes_left_next   = bytes_left_reg;
        has_data_next     = 1'b0;
        data_byte_next    = '0;
        frame_done_next   = 1'b0;
        status_next       = ST_OK;

        if (!in_body_reg) begin
            if (!is_digit) begin
                status_next       = ST_BAD_DIGIT;
                digits_seen_next  = '0;
                length_accum_next = '0;
                bytes_left_next   = '0;
            end else if (!hdr_complete) begin
                digits_seen_next  = digits_inc;
                length_accum_next = acc_new;
            end else if (acc_new == '0) begin
                status_next       = ST_ZERO_LEN;
                digits_seen_next  = '0;
                length_accum_next = '0;
                bytes_left_next   = '0;
            end else begin
                in_body_next      = 1'b1;
                bytes_left_next   = acc_new;
                digits_seen_next  = '0;
                length_accum_next = '0;
            end
        end else begin
            if (bytes_left_reg > len_t'(1)) begin
                has_data_next   = 1'b1;
                data_byte_next  = s_in_byte;
                bytes_left_next = bytes_left_reg - len_t'(1);
            end else begin
                frame_done_next   = 1'b1;
                status_next       = (s_in_byte != CHAR_NEWLINE) ? ST_NO_NEWLINE : ST_OK;
                in_body_next      = 1'b0;
                digits_seen_next  = '0;
                length_accum_next = '0;
                bytes_left_next   = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_body_reg      <= 1'b0;
            digits_seen_reg  <= '0;
            length_accum_reg <= '0;
            bytes_left_reg   <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (accept) begin
                in_body_reg      <= in_body_next;
                digits_seen_reg  <= digits_seen_next;
                length_accum_reg <= length_accum_next;
                bytes_left_reg   <= bytes_left_next;
                m_valid_reg      <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg      <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            has_data_reg   <= has_data_next;
            data_byte_reg  <= data_byte_next;
            frame_done_reg <= frame_done_next;
            status_reg     <= status_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_has_data   = has_data_reg;
    assign m_data_byte  = data_byte_reg;
    assign m_frame_done = frame_done_reg;
    assign m_status     = status_reg;

endmodule
`default_nettype wire
